FILE: rtl/core/kztb_pkg.sv
// Shared types and codes for the keyed zone table.
// No dependencies; imported by keyed_zone_table_with_bitmaps.
`default_nettype none

package kztb_pkg;

  // action codes
  localparam logic [2:0] ACT_INSERT    = 3'd0;
  localparam logic [2:0] ACT_REMOVE    = 3'd1;
  localparam logic [2:0] ACT_QUERY     = 3'd2;
  localparam logic [2:0] ACT_WR_ADDED  = 3'd3;
  localparam logic [2:0] ACT_WR_HIT    = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_ZONE   = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] zone_id;
    logic [9:0]         prop_index;
    logic               bit_value;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       previously_hit;
    logic       added_to_scene;
    logic [3:0] zone_count;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIND,
    S_MOD
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/keyed_zone_table_with_bitmaps.sv
// Keyed zone table: up to MAX_ZONES records, each a signed key plus two bitmaps.
// Depends on kztb_pkg (item types, action/status codes, state enum).
`default_nettype none

//  channel | signals                    | direction | moves
//  --------+----------------------------+-----------+-----------------------------
//  request | req_valid, req_stall, req  | in        | one action item (req_t)
//  result  | rsp_valid, rsp_stall, rsp  | out       | one result item (rsp_t)
//
// Steps: query and bit writes go through accept with key compare, priority pick
// plus bitmap memory read, and modify/write-back; insert, remove and error cases
// finish in the pick step. The registered read of the bitmap memory adds the last step.
// Reset: count cleared, slot map set to identity, word valid bits cleared at once;
// no clearing pass. Stalls: a new item is taken while a result waits; a stalled
// result holds the block in its final step until the output register frees.
module keyed_zone_table_with_bitmaps
  import kztb_pkg::*;
#(
  parameter int MAX_ZONES      = 9,
  parameter int PROPS_PER_ZONE = 600
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  wire  rsp_stall,
  output rsp_t rsp
);

  localparam int MAP_WORDS = (PROPS_PER_ZONE + 63) / 64;
  localparam int SLOT_W    = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
  localparam int DEPTH     = MAX_ZONES * MAP_WORDS;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Keys are registers: all are compared in parallel at accept.
  logic signed [31:0] keys [MAX_ZONES];
  // Logical slot -> physical bitmap record. A swap-remove swaps two map
  // entries instead of copying bitmap words.
  logic [SLOT_W-1:0]  phys_map [MAX_ZONES];
  logic [3:0]         count;

  // Bitmap memory: one word holds {added[63:0], hit[63:0]} of one 64-bit group.
  // A word whose valid bit is clear reads as zero (cleared by insert).
  logic [127:0]       mem [DEPTH];
  logic [DEPTH-1:0]   vld;
  logic [127:0]       rdata;
  logic [ADDR_W-1:0]  addr_q;

  state_t state, state_next;
  req_t   req_q;
  logic [MAX_ZONES-1:0] match;

  logic              accept, out_free, fin;
  logic              do_ins, do_rem, mem_re, mem_we;
  logic [1:0]        fin_status;
  logic              fin_hit, fin_added;
  logic              found;
  logic [SLOT_W-1:0] slot, last, ins_slot;
  logic [3:0]        count_m1;
  logic [ADDR_W-1:0] addr;
  logic              bad_index, full;
  logic [127:0]      word, wdata;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  assign count_m1  = count - 4'd1;
  assign last      = count_m1[SLOT_W-1:0];
  assign ins_slot  = count[SLOT_W-1:0];
  assign full      = (count >= 4'(MAX_ZONES));
  assign bad_index = ({1'b0, req_q.prop_index} >= 11'(PROPS_PER_ZONE));

  // First matching slot wins (duplicates allowed).
  always_comb begin
    found = 1'b0;
    slot  = '0;
    for (int i = MAX_ZONES - 1; i >= 0; i--) begin
      if (match[i]) begin
        found = 1'b1;
        slot  = SLOT_W'(i);
      end
    end
  end

  assign addr = ADDR_W'(phys_map[slot]) * ADDR_W'(MAP_WORDS)
              + ADDR_W'(req_q.prop_index[9:6]);

  assign word = vld[addr_q] ? rdata : '0;

  always_comb begin
    wdata = word;
    if (req_q.action == ACT_WR_ADDED) begin
      wdata[{1'b1, req_q.prop_index[5:0]}] = req_q.bit_value;
    end else begin
      wdata[{1'b0, req_q.prop_index[5:0]}] = req_q.bit_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    fin        = 1'b0;
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    fin_status = ST_OK;
    fin_hit    = 1'b0;
    fin_added  = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_FIND;
        end
      end
      S_FIND: begin
        case (req_q.action)
          ACT_INSERT: begin
            if (out_free) begin
              fin        = 1'b1;
              state_next = S_IDLE;
              if (full) begin
                fin_status = ST_FULL;
              end else begin
                do_ins = 1'b1;
              end
            end
          end
          ACT_REMOVE: begin
            if (out_free) begin
              fin        = 1'b1;
              state_next = S_IDLE;
              if (!found) begin
                fin_status = ST_NO_ZONE;
              end else begin
                do_rem = 1'b1;
              end
            end
          end
          ACT_QUERY, ACT_WR_ADDED, ACT_WR_HIT: begin
            if (found && !bad_index) begin
              mem_re     = 1'b1;
              state_next = S_MOD;
            end else if (out_free) begin
              fin        = 1'b1;
              state_next = S_IDLE;
              fin_status = found ? ST_BAD_INDEX : ST_NO_ZONE;
            end
          end
          default: begin
            if (out_free) begin
              fin        = 1'b1;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_MOD: begin
        if (out_free) begin
          fin        = 1'b1;
          state_next = S_IDLE;
          if (req_q.action == ACT_QUERY) begin
            fin_hit   = word[req_q.prop_index[5:0]];
            fin_added = word[{1'b1, req_q.prop_index[5:0]}];
          end else begin
            mem_we = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Item capture and parallel key compare against live records.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
      for (int i = 0; i < MAX_ZONES; i++) begin
        match[i] <= (keys[i] == req.zone_id) && (4'(i) < count);
      end
    end
  end

  // Keys hold no reset: only entries below count are ever compared.
  always_ff @(posedge clk) begin
    if (do_ins) begin
      keys[ins_slot] <= req_q.zone_id;
    end else if (do_rem) begin
      keys[slot] <= keys[last];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      vld   <= '0;
      for (int i = 0; i < MAX_ZONES; i++) begin
        phys_map[i] <= SLOT_W'(i);
      end
    end else begin
      if (do_ins) begin
        count <= count + 4'd1;
        for (int j = 0; j < DEPTH; j++) begin
          if (SLOT_W'(j / MAP_WORDS) == phys_map[ins_slot]) begin
            vld[j] <= 1'b0;
          end
        end
      end
      if (do_rem) begin
        count <= count_m1;
        // removing the last record leaves the map as it is
        if (slot != last) begin
          phys_map[slot] <= phys_map[last];
          phys_map[last] <= phys_map[slot];
        end
      end
      if (mem_we) begin
        vld[addr_q] <= 1'b1;
      end
    end
  end

  // Read and write-back never overlap on the same word: one item at a time,
  // and the write lands before the next item can issue its read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_q] <= wdata;
    end
    if (mem_re) begin
      rdata  <= mem[addr];
      addr_q <= addr;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fin) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      rsp.status         <= fin_status;
      rsp.previously_hit <= fin_hit;
      rsp.added_to_scene <= fin_added;
      rsp.zone_count     <= do_ins ? count + 4'd1 : (do_rem ? count_m1 : count);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 4'(MAX_ZONES))
    else $error("record count above table size");

  a_count_only_on_finish: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(fin) |-> $stable(count))
    else $error("record count changed without a finishing item");

  a_rsp_count_matches: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.zone_count == count)
    else $error("reported count differs from held count");

  a_write_in_modify: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == S_MOD && req_q.action != ACT_QUERY)
    else $error("bitmap write outside its read-modify-write step");

endmodule

`default_nettype wire
